[src/hta_pkg.sv]
// handle table allocator package: operation and status codes, register map,
// payload widths, memory control struct. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hta_pkg;

  // operation codes carried in func
  typedef enum logic [2:0] {
    FN_ALLOC       = 3'd0,
    FN_DESTROY     = 3'd1,
    FN_MAP         = 3'd2,
    FN_UNLOCK      = 3'd3,
    FN_FREE_LOCKED = 3'd4
  } func_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_INVALID = 3'd2,
    ST_BUSY    = 3'd3,
    ST_CLOSING = 3'd4
  } status_e;

  // register map
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_TABLE_CLOSING = 1'b0;

  // fixed payload widths
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned OBJECT_W = 31;
  localparam int unsigned ISSUED_W = 15;
  localparam int unsigned OPEN_W   = 13;

  // entry memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

[src/hta_store.sv]
// entry store: one write port, one read port with registered read data.
// depends on hta_pkg for the port control struct.
`timescale 1ns / 1ps
`default_nettype none

module hta_store #(
  parameter int unsigned WIDTH  = 44,
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire                   clk_i,
  input  hta_pkg::mem_ctl_t     ctl_i,
  input  wire  [ADDR_W-1:0]     rd_addr_i,
  input  wire  [ADDR_W-1:0]     wr_addr_i,
  input  wire  [WIDTH-1:0]      wr_data_i,
  output logic [WIDTH-1:0]      rd_data_o
);
  import hta_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[src/hta_regs.sv]
// configuration registers behind the apb-style port.
// depends on hta_pkg for the register map.
`timescale 1ns / 1ps
`default_nettype none

module hta_regs (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [hta_pkg::ADDR_W-1:0] paddr,
  input  wire  [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic                      closing_o
);
  import hta_pkg::*;

  logic closing_q;
  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_TABLE_CLOSING);

  // table closing flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closing_q <= 1'b0;
    end else if (wr_hit) begin
      closing_q <= pwdata[0];
    end
  end

  // read back
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TABLE_CLOSING) begin
      prdata = {31'd0, closing_q};
    end
  end

  assign closing_o = closing_q;

endmodule

`default_nettype wire

[src/hta_ctrl.sv]
// sequencer: reads an entry, decides the operation, writes the entry back,
// chains a freshly opened chunk and holds the result. depends on hta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hta_ctrl #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned CHUNK  = 512,
  parameter int unsigned OBJ_W  = 31,
  parameter int unsigned IDX_W  = $clog2(DEPTH),
  parameter int unsigned ENT_W  = OBJ_W + IDX_W + 2
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            closing_i,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [2:0]                     func_i,
  input  wire  [hta_pkg::HANDLE_W-1:0]   handle_i,
  input  wire  [hta_pkg::OBJECT_W-1:0]   object_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [2:0]                     status_o,
  output logic [hta_pkg::ISSUED_W-1:0]   issued_handle_o,
  output logic [hta_pkg::OBJECT_W-1:0]   found_object_o,
  output logic [hta_pkg::OPEN_W-1:0]     open_count_o,
  output hta_pkg::mem_ctl_t              mem_ctl_o,
  output logic [IDX_W-1:0]               rd_addr_o,
  output logic [IDX_W-1:0]               wr_addr_o,
  output logic [ENT_W-1:0]               wr_data_o,
  input  wire  [ENT_W-1:0]               rd_data_i
);
  import hta_pkg::*;

  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned NONE_BIT = OBJ_W + IDX_W;
  localparam int unsigned LOCK_BIT = NONE_BIT + 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CHAIN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [2:0]        func_q;
  logic [OBJ_W-1:0]  obj_q;
  logic              hvalid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              head_none_q, head_none_d;
  logic [CNT_W-1:0]  high_q, high_d;
  logic [CNT_W-1:0]  inuse_q, inuse_d;
  logic [CNT_W-1:0]  chain_i_q, chain_i_d;
  logic [CNT_W-1:0]  chain_end_q, chain_end_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [ISSUED_W-1:0] issued_q, issued_d;
  logic [OBJECT_W-1:0] found_q, found_d;
  logic [OPEN_W-1:0] open_q, open_d;

  logic              accept;
  logic [29:0]       hq, hq_m1;
  logic              h_in_range;
  logic [IDX_W-1:0]  h_idx;

  // entry fields from the read port
  logic [OBJ_W-1:0]  rd_obj;
  logic [IDX_W-1:0]  rd_link;
  logic              rd_none;
  logic              rd_lock;
  logic              entry_used;
  logic              can_out;

  assign rd_obj  = rd_data_i[OBJ_W-1:0];
  assign rd_link = rd_data_i[NONE_BIT-1:OBJ_W];
  assign rd_none = rd_data_i[NONE_BIT];
  assign rd_lock = rd_data_i[LOCK_BIT];

  // handle decode: index = (handle >> 2) - 1, bounded by the high water mark
  assign hq         = handle_i[31:2];
  assign hq_m1      = hq - 30'd1;
  assign h_in_range = (hq != 30'd0) && (hq <= 30'(high_q));
  assign h_idx      = hq_m1[IDX_W-1:0];

  // input transaction and entry read
  assign in_stall_o      = (state_q != S_IDLE);
  assign accept          = in_valid_i && !in_stall_o;
  assign mem_ctl_o.rd_en = accept;
  assign rd_addr_o       = (func_e'(func_i) == FN_ALLOC) ? head_q : h_idx;

  assign entry_used = hvalid_q && (rd_obj != '0);
  assign can_out    = !out_valid_q || !out_stall_i;

  // operation decision and write back
  always_comb begin
    logic [31:0]      sum32;
    logic [31:0]      iss32;
    logic [31:0]      open32;
    logic [CNT_W-1:0] end_v;
    logic [CNT_W-1:0] nxt;
    logic [CNT_W-1:0] cnxt;

    state_d         = state_q;
    head_d          = head_q;
    head_none_d     = head_none_q;
    high_d          = high_q;
    inuse_d         = inuse_q;
    chain_i_d       = chain_i_q;
    chain_end_d     = chain_end_q;
    out_valid_d     = out_valid_q && out_stall_i;
    status_d        = status_q;
    issued_d        = issued_q;
    found_d         = found_q;
    open_d          = open_q;
    mem_ctl_o.wr_en = 1'b0;
    wr_addr_o       = idx_q;
    wr_data_o       = rd_data_i;
    sum32           = 32'(high_q) + 32'(CHUNK);
    end_v           = (sum32 > 32'(DEPTH)) ? CNT_W'(DEPTH) : sum32[CNT_W-1:0];
    nxt             = high_q + CNT_W'(1);
    cnxt            = chain_i_q + CNT_W'(1);
    iss32           = 32'd0;
    open32          = 32'd0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_out) begin
          out_valid_d = 1'b1;
          status_d    = ST_INVALID;
          issued_d    = '0;
          found_d     = '0;
          state_d     = S_IDLE;
          case (func_q)
            FN_ALLOC: begin
              if (obj_q == '0) begin
                status_d = ST_INVALID;
              end else if (!head_none_q) begin
                // pop the free list
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o   = head_q;
                wr_data_o   = {1'b0, rd_none, rd_link, obj_q};
                head_d      = rd_link;
                head_none_d = rd_none;
                inuse_d     = inuse_q + CNT_W'(1);
                iss32       = (32'(head_q) + 32'd1) << 2;
                issued_d    = iss32[ISSUED_W-1:0];
                status_d    = ST_OK;
              end else if (high_q >= CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                // open a new chunk, issue its first entry
                mem_ctl_o.wr_en = 1'b1;
                wr_addr_o   = high_q[IDX_W-1:0];
                wr_data_o   = {1'b0, 1'b1, IDX_W'(0), obj_q};
                high_d      = end_v;
                chain_end_d = end_v;
                inuse_d     = inuse_q + CNT_W'(1);
                iss32       = (32'(high_q) + 32'd1) << 2;
                issued_d    = iss32[ISSUED_W-1:0];
                status_d    = ST_OK;
                if (nxt < end_v) begin
                  head_d      = nxt[IDX_W-1:0];
                  head_none_d = 1'b0;
                  chain_i_d   = nxt;
                  state_d     = S_CHAIN;
                end else begin
                  head_none_d = 1'b1;
                end
              end
            end
            FN_DESTROY, FN_MAP: begin
              if (!entry_used) begin
                status_d = ST_INVALID;
              end else if (closing_i) begin
                status_d = ST_CLOSING;
              end else if (rd_lock) begin
                status_d = ST_BUSY;
              end else if (func_q == FN_DESTROY) begin
                mem_ctl_o.wr_en = 1'b1;
                wr_data_o   = {1'b0, head_none_q, head_q, OBJ_W'(0)};
                head_d      = idx_q;
                head_none_d = 1'b0;
                if (inuse_q != '0) begin
                  inuse_d = inuse_q - CNT_W'(1);
                end
                status_d = ST_OK;
              end else begin
                mem_ctl_o.wr_en = 1'b1;
                wr_data_o = {1'b1, rd_none, rd_link, rd_obj};
                found_d   = OBJECT_W'(rd_obj);
                status_d  = ST_OK;
              end
            end
            FN_UNLOCK: begin
              if (entry_used) begin
                mem_ctl_o.wr_en = 1'b1;
                wr_data_o = {1'b0, rd_none, rd_link, rd_obj};
                status_d  = ST_OK;
              end
            end
            FN_FREE_LOCKED: begin
              if (entry_used && rd_lock) begin
                mem_ctl_o.wr_en = 1'b1;
                wr_data_o   = {1'b0, head_none_q, head_q, OBJ_W'(0)};
                head_d      = idx_q;
                head_none_d = 1'b0;
                if (inuse_q != '0) begin
                  inuse_d = inuse_q - CNT_W'(1);
                end
                status_d = ST_OK;
              end
            end
            default: begin
              status_d = ST_INVALID;
            end
          endcase
          open32 = 32'(inuse_d);
          open_d = open32[OPEN_W-1:0];
        end
      end
      S_CHAIN: begin
        // link the rest of the chunk in ascending order, last one marked none
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o = chain_i_q[IDX_W-1:0];
        wr_data_o = {1'b0, (cnxt == chain_end_q), cnxt[IDX_W-1:0], OBJ_W'(0)};
        chain_i_d = cnxt;
        if (cnxt == chain_end_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '1;
      head_none_q <= 1'b1;
      high_q      <= '0;
      inuse_q     <= '0;
      chain_i_q   <= '0;
      chain_end_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      head_none_q <= head_none_d;
      high_q      <= high_d;
      inuse_q     <= inuse_d;
      chain_i_q   <= chain_i_d;
      chain_end_q <= chain_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured transaction and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      obj_q    <= object_i[OBJ_W-1:0];
      hvalid_q <= h_in_range;
      idx_q    <= h_idx;
    end
    status_q <= status_d;
    issued_q <= issued_d;
    found_q  <= found_d;
    open_q   <= open_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign issued_handle_o = issued_q;
  assign found_object_o  = found_q;
  assign open_count_o    = open_q;

  // handles in use never pass the opened range
  a_inuse_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inuse_q <= high_q) else $error("handles in use above high water");

  // high water never passes the store depth
  a_high_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    high_q <= CNT_W'(DEPTH)) else $error("high water above depth");

  // free list head always names an opened entry
  a_head_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_none_q |-> (CNT_W'(head_q) < high_q)) else $error("free head outside opened range");

  // chaining stays inside the chunk that was just opened
  a_chain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAIN) |-> (chain_i_q < chain_end_q) && (chain_end_q == high_q))
    else $error("chain pointer out of chunk");

  // an item in execution with the output free has its result registered in out_valid_q
  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) && can_out |=> out_valid_q) else $error("result lost");

endmodule

`default_nettype wire

[src/handle_table_allocator.sv]
// handle table allocator: the entry is read on the accepting edge, then in
// the execute state the operation is decided, the entry written back and the
// result register loaded; no new request is taken before the sequencer is
// idle again. opening a new chunk stalls input further while the chain write
// walks the chunk; a result that is not taken holds the execute state. reset
// clears the list head, counters and handshake state; the entry memory is not
// cleared, lookups stay below the high water mark, so no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none

module handle_table_allocator #(
  parameter int unsigned DEPTH       = 4096,
  parameter int unsigned CHUNK       = 512,
  parameter int unsigned OBJECT_BITS = 31
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [hta_pkg::ADDR_W-1:0]     paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  // request channel
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  [2:0]                     func_i,
  input  wire  [hta_pkg::HANDLE_W-1:0]   handle_i,
  input  wire  [hta_pkg::OBJECT_W-1:0]   object_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic [2:0]                     status_o,
  output logic [hta_pkg::ISSUED_W-1:0]   issued_handle_o,
  output logic [hta_pkg::OBJECT_W-1:0]   found_object_o,
  output logic [hta_pkg::OPEN_W-1:0]     open_count_o
);
  import hta_pkg::*;

  localparam int unsigned OBJ_W = (OBJECT_BITS < OBJECT_W) ? OBJECT_BITS : OBJECT_W;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned ENT_W = OBJ_W + IDX_W + 2;

  logic             closing;
  mem_ctl_t         mem_ctl;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;
  logic [ENT_W-1:0] rd_data;

  // configuration registers
  hta_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .closing_o (closing)
  );

  // entry memory
  hta_store #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // sequencer
  hta_ctrl #(
    .DEPTH (DEPTH),
    .CHUNK (CHUNK),
    .OBJ_W (OBJ_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .closing_i       (closing),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .handle_i        (handle_i),
    .object_i        (object_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .issued_handle_o (issued_handle_o),
    .found_object_o  (found_object_o),
    .open_count_o    (open_count_o),
    .mem_ctl_o       (mem_ctl),
    .rd_addr_o       (rd_addr),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_data_i       (rd_data)
  );

endmodule

`default_nettype wire

[tb/tb_handle_table_allocator.sv]
`timescale 1ns / 1ps
// self-checking testbench for handle_table_allocator: directed and random
// requests checked against an in-bench model of the handle table.
// depends on hta_pkg and the handle_table_allocator rtl.

module tb_handle_table_allocator;
  import hta_pkg::*;

  localparam int TBL_DEPTH  = 4096;
  localparam int CHUNK_SIZE = 512;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 7;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam int NO_ENTRY   = -1;
  localparam int MAX_PRINTS = 40;
  localparam logic [ADDR_W-1:0] CLOSING_ADDR = ADDR_W'(4 * REG_TABLE_CLOSING);

  typedef struct packed {
    logic [2:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic [OBJECT_W-1:0] object;
  } request_t;

  typedef struct packed {
    status_e             status;
    logic [ISSUED_W-1:0] issued;
    logic [OBJECT_W-1:0] found;
    logic [OPEN_W-1:0]   open_cnt;
  } outcome_t;

  // clock, reset and block ports
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [2:0]          func = '0;
  logic [HANDLE_W-1:0] handle = '0;
  logic [OBJECT_W-1:0] object = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          status;
  logic [ISSUED_W-1:0] issued;
  logic [OBJECT_W-1:0] found;
  logic [OPEN_W-1:0]   open_cnt;

  // table model state
  logic [OBJECT_W-1:0] tbl_obj  [TBL_DEPTH];
  logic                tbl_lock [TBL_DEPTH];
  int                  tbl_next [TBL_DEPTH];
  int                  free_head = NO_ENTRY;
  int                  in_use_cnt = 0;
  int                  high_water = 0;
  logic                closing_cfg = 1'b0;
  int                  live_q[$];
  int                  full_hits = 0;

  // stimulus and checking bookkeeping
  request_t            request_q[$];
  outcome_t            pending_outcomes_q[$];
  request_t            held_req;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  gen_cnt = 0;
  int                  result_cnt = 0;
  int                  mismatch_count = 0;

  handle_table_allocator #(
    .DEPTH       (TBL_DEPTH),
    .CHUNK       (CHUNK_SIZE),
    .OBJECT_BITS (OBJECT_W)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func),
    .handle_i        (handle),
    .object_i        (object),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .issued_handle_o (issued),
    .found_object_o  (found),
    .open_count_o    (open_cnt)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // handle decode: index below high water and entry in use
  function automatic bit find_entry(input logic [HANDLE_W-1:0] h, output int idx);
    logic [HANDLE_W-3:0] q;
    q = h[HANDLE_W-1:2];
    idx = 0;
    if (q == '0) return 1'b0;
    idx = int'(q) - 1;
    if (idx >= high_water) return 1'b0;
    return tbl_obj[idx] != '0;
  endfunction

  // clear an entry and push it on the free list
  function automatic void release_entry(int idx);
    int k;
    tbl_obj[idx] = '0;
    tbl_lock[idx] = 1'b0;
    tbl_next[idx] = free_head;
    free_head = idx;
    if (in_use_cnt > 0) in_use_cnt--;
    for (k = 0; k < live_q.size(); k++) begin
      if (live_q[k] == idx) begin
        live_q.delete(k);
        break;
      end
    end
  endfunction

  // next state and result of the table for one request
  function automatic outcome_t table_outcome(request_t r);
    outcome_t o;
    int idx;
    int stop;
    int i;
    bit granted;
    o.status = ST_INVALID;
    o.issued = '0;
    o.found = '0;
    granted = 1'b0;
    idx = 0;
    case (r.func)
      FN_ALLOC: begin
        if (r.object == '0) begin
          o.status = ST_INVALID;
        end else if (free_head != NO_ENTRY) begin
          idx = free_head;
          free_head = tbl_next[idx];
          granted = 1'b1;
        end else if (high_water >= TBL_DEPTH) begin
          o.status = ST_FULL;
          full_hits++;
        end else begin
          // open the next chunk, chain its tail in ascending order
          stop = (high_water + CHUNK_SIZE > TBL_DEPTH) ? TBL_DEPTH : high_water + CHUNK_SIZE;
          idx = high_water;
          for (i = idx + 1; i < stop; i++) begin
            tbl_obj[i] = '0;
            tbl_lock[i] = 1'b0;
            tbl_next[i] = (i + 1 < stop) ? i + 1 : NO_ENTRY;
          end
          free_head = (idx + 1 < stop) ? idx + 1 : NO_ENTRY;
          high_water = stop;
          granted = 1'b1;
        end
        if (granted) begin
          tbl_obj[idx] = r.object;
          tbl_lock[idx] = 1'b0;
          tbl_next[idx] = 0;
          in_use_cnt++;
          live_q.push_back(idx);
          o.issued = ISSUED_W'((idx + 1) << 2);
          o.status = ST_OK;
        end
      end
      FN_DESTROY, FN_MAP: begin
        if (!find_entry(r.handle, idx)) o.status = ST_INVALID;
        else if (closing_cfg) o.status = ST_CLOSING;
        else if (tbl_lock[idx]) o.status = ST_BUSY;
        else if (r.func == FN_DESTROY) begin
          release_entry(idx);
          o.status = ST_OK;
        end else begin
          tbl_lock[idx] = 1'b1;
          o.found = tbl_obj[idx];
          o.status = ST_OK;
        end
      end
      FN_UNLOCK: begin
        if (find_entry(r.handle, idx)) begin
          tbl_lock[idx] = 1'b0;
          o.status = ST_OK;
        end
      end
      FN_FREE_LOCKED: begin
        if (find_entry(r.handle, idx) && tbl_lock[idx]) begin
          release_entry(idx);
          o.status = ST_OK;
        end
      end
      default: o.status = ST_INVALID;
    endcase
    o.open_cnt = OPEN_W'(in_use_cnt);
    return o;
  endfunction

  // request driver: predicts each transaction as it is accepted
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      func <= '0;
      handle <= '0;
      object <= '0;
    end else begin
      if (in_valid && !in_stall) pending_outcomes_q.push_back(table_outcome(held_req));
      if (!in_valid || !in_stall) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          held_req = request_q.pop_front();
          in_valid <= 1'b1;
          func <= held_req.func;
          handle <= held_req.handle;
          object <= held_req.object;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // compare one result transaction with the oldest expected outcome
  task automatic check_outcome();
    outcome_t want;
    if (pending_outcomes_q.size() == 0) begin
      note_mismatch($sformatf("unexpected result, status %0d", status));
      return;
    end
    want = pending_outcomes_q.pop_front();
    if (status !== want.status)
      note_mismatch($sformatf("result %0d status %0d, want %0d", result_cnt, status,
                              want.status));
    if (issued !== want.issued)
      note_mismatch($sformatf("result %0d issued handle %0h, want %0h", result_cnt, issued,
                              want.issued));
    if (found !== want.found)
      note_mismatch($sformatf("result %0d found object %0h, want %0h", result_cnt, found,
                              want.found));
    if (open_cnt !== want.open_cnt)
      note_mismatch($sformatf("result %0d open count %0d, want %0d", result_cnt, open_cnt,
                              want.open_cnt));
    result_cnt++;
  endtask

  // result monitor with random stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_outcome();
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // register write: setup then access cycle
  task automatic write_closing(input logic value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CLOSING_ADDR;
    pwdata <= {31'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    closing_cfg = value;
  endtask

  // hand a request to the driver, keeping the backlog short
  task automatic enqueue(input request_t r);
    int mode;
    while (request_q.size() >= 2) @(negedge clk);
    request_q.push_back(r);
    gen_cnt++;
    // rotate idle and stall pattern every hundred requests
    if (gen_cnt % 100 == 0) begin
      mode = (gen_cnt / 100) % 4;
      send_idle_pct = (mode == 1) ? 54 : (mode == 3) ? 27 : 0;
      stall_pct = (mode == 2) ? 54 : (mode == 3) ? 27 : 0;
    end
  endtask

  task automatic push_req(input logic [2:0] f, input logic [HANDLE_W-1:0] h,
                          input logic [OBJECT_W-1:0] ob);
    request_t r;
    r.func = f;
    r.handle = h;
    r.object = ob;
    enqueue(r);
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int sel;
    sel = $urandom_range(99);
    if (live_q.size() > 0 && sel < 72)
      return HANDLE_W'((live_q[$urandom_range(live_q.size() - 1)] + 1) << 2) |
             HANDLE_W'($urandom_range(3));
    if (sel < 82) return HANDLE_W'(($urandom_range(high_water) + 1) << 2);
    if (sel < 87) return HANDLE_W'($urandom_range(3));
    return $urandom();
  endfunction

  function automatic logic [OBJECT_W-1:0] pick_object();
    int sel;
    sel = $urandom_range(99);
    if (sel < 4) return '0;
    if (sel < 7) return '1;
    if (sel < 10) return OBJECT_W'(1);
    return OBJECT_W'($urandom());
  endfunction

  function automatic request_t random_request(int alloc_pct);
    request_t r;
    int sel;
    r.handle = pick_handle();
    r.object = OBJECT_W'($urandom());
    sel = $urandom_range(99);
    if ($urandom_range(99) < alloc_pct) begin
      r.func = FN_ALLOC;
      r.handle = $urandom();
      r.object = pick_object();
    end else if (sel < 25) r.func = FN_DESTROY;
    else if (sel < 50) r.func = FN_MAP;
    else if (sel < 70) r.func = FN_UNLOCK;
    else if (sel < 93) r.func = FN_FREE_LOCKED;
    else r.func = 3'($urandom_range(7, int'(FN_FREE_LOCKED) + 1));
    return r;
  endfunction

  // lock, contend, then release through unlock or free of the locked entry
  task automatic push_lock_sequence();
    logic [HANDLE_W-1:0] h;
    if (live_q.size() == 0) begin
      push_req(FN_ALLOC, $urandom(), pick_object());
      return;
    end
    h = HANDLE_W'((live_q[$urandom_range(live_q.size() - 1)] + 1) << 2);
    push_req(FN_MAP, h, OBJECT_W'($urandom()));
    if ($urandom_range(1)) begin
      push_req(FN_MAP, h | HANDLE_W'($urandom_range(3)), OBJECT_W'($urandom()));
      push_req(FN_DESTROY, h, OBJECT_W'($urandom()));
    end
    if ($urandom_range(1)) begin
      push_req(FN_UNLOCK, h, OBJECT_W'($urandom()));
      if ($urandom_range(1)) push_req(FN_DESTROY, h, OBJECT_W'($urandom()));
    end else begin
      push_req(FN_FREE_LOCKED, h, OBJECT_W'($urandom()));
    end
  endtask

  task automatic run_mixed(input int n, input int alloc_pct);
    int k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) push_lock_sequence();
      else enqueue(random_request(alloc_pct));
    end
  endtask

  // block until every request is accepted and every result has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_valid || pending_outcomes_q.size() != 0);
  endtask

  // main sequence
  initial begin
    int guard;
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_closing(1'b0);

    // directed: allocation, locking, bad handles, unused codes
    push_req(FN_ALLOC, '0, '0);
    push_req(FN_ALLOC, '0, OBJECT_W'(1));
    push_req(FN_ALLOC, '1, '1);
    push_req(FN_MAP, HANDLE_W'(4), '0);
    push_req(FN_MAP, HANDLE_W'(4), '0);
    push_req(FN_DESTROY, HANDLE_W'(4), '0);
    push_req(FN_UNLOCK, HANDLE_W'(7), '0);
    push_req(FN_UNLOCK, HANDLE_W'(8), '0);
    push_req(FN_FREE_LOCKED, HANDLE_W'(8), '0);
    push_req(FN_MAP, HANDLE_W'(8), '0);
    push_req(FN_FREE_LOCKED, HANDLE_W'(8), '0);
    push_req(FN_DESTROY, HANDLE_W'(0), '0);
    push_req(FN_DESTROY, HANDLE_W'(3), '0);
    push_req(FN_MAP, '1, '1);
    push_req(FN_MAP, HANDLE_W'((CHUNK_SIZE + 1) << 2), '0);
    push_req(FN_DESTROY, HANDLE_W'(4), '0);
    push_req(FN_DESTROY, HANDLE_W'(4), '0);
    for (k = 1; k <= 3; k++) push_req(3'(int'(FN_FREE_LOCKED) + k), HANDLE_W'(4), '1);
    push_req(FN_ALLOC, '0, OBJECT_W'(5));
    wait_idle();

    // directed: table shutting down
    write_closing(1'b1);
    push_req(FN_ALLOC, '0, OBJECT_W'('h55));
    push_req(FN_MAP, HANDLE_W'(4), '0);
    push_req(FN_DESTROY, HANDLE_W'(8), '0);
    push_req(FN_MAP, HANDLE_W'('h100000), '0);
    push_req(FN_UNLOCK, HANDLE_W'(4), '0);
    push_req(FN_FREE_LOCKED, HANDLE_W'(4), '0);
    wait_idle();

    // random traffic, open and closing table
    write_closing(1'b0);
    run_mixed(350, 35);
    wait_idle();
    write_closing(1'b1);
    run_mixed(200, 30);
    wait_idle();
    write_closing(1'b0);
    run_mixed(300, 40);

    // allocation-heavy burst that opens further chunks
    guard = 0;
    while (full_hits < 6 && guard < 300) begin
      enqueue(random_request(92));
      guard++;
    end
    wait_idle();

    // mostly frees, then a balanced mix
    run_mixed(200, 10);
    run_mixed(100, 35);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
src/hta_pkg.sv
src/hta_store.sv
src/hta_regs.sv
src/hta_ctrl.sv
src/handle_table_allocator.sv
tb/tb_handle_table_allocator.sv
